// ----- hw/rtl/lruc_pkg.sv -----
// lruc_pkg: shared sizes, operation codes and controller command type for the
// lru key-value cache. Depends on nothing; used by every module of the block.
package lruc_pkg;

    // store geometry
    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int RANK_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_BITS   = $clog2(CAPACITY + 1);
    localparam int LIMIT_BITS = 5;

    // capacity limit after reset
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

    // stream packing, rounded up to whole bytes
    localparam int IN_DATA_BITS  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 + VALUE_BITS + KEY_BITS + 7) / 8) * 8;

    // operation codes
    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // load a new item into the item register
        logic commit;   // apply the lookup result and load the output register
    } t_dp_cmd;

endpackage

// ----- hw/rtl/lruc_ctrl.sv -----
// lruc_ctrl: handshake controller for the lru key-value cache.
// Depends on lruc_pkg (t_dp_cmd); drives the datapath through o_cmd.
module lruc_ctrl
    import lruc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   commit;

    // beat handshake and commit condition
    assign accept = i_in_valid && r_in_ready;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // next state and registered outputs
    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_EXEC;
                    n_in_ready = 1'b0;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_in_ready  = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = r_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.commit  = commit;

    // a committed item always shows a result beat next
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("commit did not raise output valid");

    // no second beat is taken while an item is in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_in_ready && r_state == S_EXEC)
        else $error("input ready while item in flight");

    // a stalled result is never overwritten or dropped
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && !$past(commit)))
        else $error("stalled result lost");

endmodule

// ----- hw/rtl/lruc_dp.sv -----
// lruc_dp: entry store, parallel key match, lru rank update and result register.
// Depends on lruc_pkg (sizes, t_kind, t_dp_cmd); commanded by lruc_ctrl.
module lruc_dp
    import lruc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_data,
    input  logic                  i_kind,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key
);

    // configuration and item registers
    logic [LIMIT_BITS-1:0] r_limit;
    t_kind                 r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // entry store
    logic [CAPACITY-1:0]   r_valid, n_valid;
    logic [KEY_BITS-1:0]   r_ekey [CAPACITY];
    logic [VALUE_BITS-1:0] r_edata [CAPACITY];
    logic [RANK_BITS-1:0]  r_erank [CAPACITY];
    logic [RANK_BITS-1:0]  n_erank [CAPACITY];
    logic [OCC_BITS-1:0]   r_occ, n_occ;

    // result registers
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_rd;
    logic                  r_ev;
    logic [KEY_BITS-1:0]   r_evk;

    // lookup signals
    logic [CAPACITY-1:0]   match;
    logic [CAPACITY-1:0]   victim;
    logic [CAPACITY-1:0]   kept;
    logic [CAPACITY-1:0]   empty;
    logic [CAPACITY-1:0]   free_oh;
    logic                  hit;
    logic                  need_evict;
    logic                  insert;
    logic [RANK_BITS-1:0]  hit_rank;
    logic [VALUE_BITS-1:0] hit_data;
    logic [KEY_BITS-1:0]   victim_key;
    logic [OCC_BITS-1:0]   limit;
    logic [OCC_BITS-1:0]   occ_m1;
    logic [RANK_BITS-1:0]  last_rank;

    // effective limit: zero acts as one, clamp to store size
    always_comb begin
        if (r_limit == '0) begin
            limit = OCC_BITS'(1);
        end else if (OCC_BITS'(r_limit) > OCC_BITS'(CAPACITY)) begin
            limit = OCC_BITS'(CAPACITY);
        end else begin
            limit = OCC_BITS'(r_limit);
        end
    end

    // least recent entry holds rank occupancy-1
    assign occ_m1    = r_occ - OCC_BITS'(1);
    assign last_rank = occ_m1[RANK_BITS-1:0];

    // parallel compare and one-hot reads
    always_comb begin
        hit_rank   = '0;
        hit_data   = '0;
        victim_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i]  = r_valid[i] && (r_ekey[i] == r_key);
            victim[i] = r_valid[i] && (r_erank[i] == last_rank);
            if (match[i]) begin
                hit_rank = hit_rank | r_erank[i];
                hit_data = hit_data | r_edata[i];
            end
            if (victim[i]) begin
                victim_key = victim_key | r_ekey[i];
            end
        end
    end

    assign hit        = |match;
    assign need_evict = !hit && (r_kind == KIND_PUT) && (r_occ >= limit) && (r_occ != '0);
    assign kept       = need_evict ? (r_valid & ~victim) : r_valid;
    // lowest free slot after eviction
    assign empty      = ~kept;
    assign free_oh    = empty & (~empty + CAPACITY'(1));
    assign insert     = !hit && (r_kind == KIND_PUT) && (|empty);

    // rank and valid update
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < CAPACITY; i++) begin
            n_erank[i] = r_erank[i];
            if (hit) begin
                if (match[i]) begin
                    n_erank[i] = '0;
                end else if (r_valid[i] && r_erank[i] < hit_rank) begin
                    n_erank[i] = r_erank[i] + RANK_BITS'(1);
                end
            end else if (insert) begin
                if (free_oh[i]) begin
                    n_erank[i] = '0;
                end else if (kept[i]) begin
                    n_erank[i] = r_erank[i] + RANK_BITS'(1);
                end
            end
        end
        if (insert) begin
            n_valid = kept | free_oh;
            n_occ   = need_evict ? r_occ : r_occ + OCC_BITS'(1);
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= t_kind'(i_kind);
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_cmd.commit) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_erank[i] <= n_erank[i];
                if ((insert && free_oh[i]) || (r_kind == KIND_PUT && match[i])) begin
                    r_edata[i] <= r_value;
                end
                if (insert && free_oh[i]) begin
                    r_ekey[i] <= r_key;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit <= hit;
            r_rd  <= (hit && r_kind == KIND_GET) ? hit_data : '0;
            r_ev  <= need_evict;
            r_evk <= need_evict ? victim_key : '0;
        end
    end

    assign o_hit         = r_hit;
    assign o_read_value  = r_rd;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evk;

    // occupancy counts the valid entries
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy does not match valid bits");

    // an eviction always finds exactly one least recent entry
    a_one_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && need_evict) |-> $onehot(victim))
        else $error("eviction without a unique victim");

    // a hit touches exactly one entry
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(match))
        else $error("key stored in more than one entry");

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// lru_key_value_cache: top level of the fully associative lru key-value cache.
// Depends on lruc_pkg, lruc_ctrl and lruc_dp.
//
// Each request beat (get or put with a key and value) yields exactly one
// result beat. A request loads the beat into the item register, then does the
// parallel key compare and rank update across all 16 entries in the execute
// state; no new beat is accepted until that item commits. The result waits in
// an output register; while it is not taken, the next item already loaded holds
// in its execute state. Valid bits clear on reset, no clearing pass. The capacity
// limit is written on the config channel, always ready; the user must write it
// only while the cache is idle, not enforced by the block; 0 acts as 1, above 16 as 16.
module lru_key_value_cache
    import lruc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,   // key[15:0], value[47:16]
    input  logic                     i_s_axis_tuser,   // kind[0]
    // result stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,   // hit[0], read_value[32:1],
                                                       // evicted[33], evicted_key[49:34],
                                                       // zero[55:50]
    // capacity limit write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LIMIT_BITS-1:0]    i_cfg_data        // capacity_in_use[4:0]
);

    t_dp_cmd               cmd;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;

    // config channel never stalls
    assign o_cfg_ready = 1'b1;

    // handshake controller
    lruc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    // entry store and lookup
    lruc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_s_axis_tuser),
        .i_key         (i_s_axis_tdata[KEY_BITS-1:0]),
        .i_value       (i_s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .o_hit         (hit),
        .o_read_value  (read_value),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key)
    );

    // result beat packing, zero filled to whole bytes
    assign o_m_axis_tdata = OUT_DATA_BITS'({evicted_key, evicted, read_value, hit});

endmodule

// ----- tb/lru_key_value_cache_tb.sv -----
// lru_key_value_cache_tb: self-checking stream testbench for the lru key-value cache.
// Depends on lruc_pkg and lru_key_value_cache; a local lru model predicts each result
// beat, which is checked field by field under random idling and a long output stall.
module lru_key_value_cache_tb;
    import lruc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 150;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        t_kind                 kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_request;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } t_access_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata = '0;   // key[15:0], value[47:16]
    logic                     i_s_axis_tuser = 1'b0; // kind[0]
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;        // hit[0], read_value[32:1],
                                                     // evicted[33], evicted_key[49:34]
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [LIMIT_BITS-1:0]    i_cfg_data = '0;       // capacity_in_use[4:0]

    // stimulus and expectation stores
    t_request       pending_requests[$];
    t_access_result expected_results[$];

    // model of the store
    logic                  line_valid[CAPACITY];
    logic [KEY_BITS-1:0]   line_key[CAPACITY];
    logic [VALUE_BITS-1:0] line_data[CAPACITY];
    int                    line_rank[CAPACITY];
    int                    line_count;
    logic [LIMIT_BITS-1:0] model_limit;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    logic stall_go = 1'b0;

    int error_count = 0;
    int cycle_count = 0;
    int beats_in = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int evictions_seen = 0;

    lru_key_value_cache DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // lookup, update and replacement of one access, returns the result beat
    task automatic lru_access(input t_request req, output t_access_result res);
        int slot;
        int victim;
        int free_slot;
        int lim;
        int old_rank;
        res = '0;
        slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot < 0 && line_valid[i] && line_key[i] == req.key) slot = i;
        end
        if (slot >= 0) begin
            res.hit = 1'b1;
            if (req.kind == KIND_GET) res.read_value = line_data[slot];
            else line_data[slot] = req.value;
            old_rank = line_rank[slot];
            for (int j = 0; j < CAPACITY; j++) begin
                if (line_valid[j] && line_rank[j] < old_rank) line_rank[j]++;
            end
            line_rank[slot] = 0;
        end else if (req.kind == KIND_PUT) begin
            lim = (model_limit == 0) ? 1 : (model_limit > CAPACITY ? CAPACITY : model_limit);
            // evict the oldest entry when at or above the limit
            if (line_count >= lim && line_count > 0) begin
                victim = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim]))
                        victim = i;
                end
                res.evicted = 1'b1;
                res.evicted_key = line_key[victim];
                line_valid[victim] = 1'b0;
                line_count--;
            end
            free_slot = -1;
            for (int i = 0; i < CAPACITY; i++) begin
                if (free_slot < 0 && !line_valid[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (line_valid[i]) line_rank[i]++;
                end
                line_valid[free_slot] = 1'b1;
                line_key[free_slot] = req.key;
                line_data[free_slot] = req.value;
                line_rank[free_slot] = 0;
                line_count++;
            end
        end
    endtask

    // request driver, fed from the pending queue
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = pending_requests.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {nxt.value, nxt.key};
                i_s_axis_tuser <= nxt.kind;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result ready with random idling and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // long hold-off on the result side, the sender keeps going
    initial begin
        wait (stall_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor: check result beats, then predict accepted request beats
    always @(posedge i_clk) begin : watch_beats
        t_request req;
        t_access_result got;
        t_access_result want;
        t_access_result res;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) line_valid[i] = 1'b0;
            line_count = 0;
            model_limit = LIMIT_RESET;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.hit = o_m_axis_tdata[0];
                got.read_value = o_m_axis_tdata[32:1];
                got.evicted = o_m_axis_tdata[33];
                got.evicted_key = o_m_axis_tdata[49:34];
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result beat with nothing expected: %h",
                                           o_m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit)
                        report_error($sformatf("result %0d hit: got %0b want %0b",
                                               results_checked, got.hit, want.hit));
                    if (got.read_value !== want.read_value)
                        report_error($sformatf("result %0d read_value: got %h want %h",
                                               results_checked, got.read_value,
                                               want.read_value));
                    if (got.evicted !== want.evicted)
                        report_error($sformatf("result %0d evicted: got %0b want %0b",
                                               results_checked, got.evicted, want.evicted));
                    if (got.evicted_key !== want.evicted_key)
                        report_error($sformatf("result %0d evicted_key: got %h want %h",
                                               results_checked, got.evicted_key,
                                               want.evicted_key));
                    if (o_m_axis_tdata[OUT_DATA_BITS-1:50] !== '0)
                        report_error($sformatf("result %0d pad bits not zero: %h",
                                               results_checked, o_m_axis_tdata));
                    results_checked++;
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                req.kind = t_kind'(i_s_axis_tuser);
                req.key = i_s_axis_tdata[15:0];
                req.value = i_s_axis_tdata[47:16];
                lru_access(req, res);
                expected_results.push_back(res);
                beats_in++;
                if (res.hit) hits_seen++;
                if (res.evicted) evictions_seen++;
            end
            if (i_cfg_valid && o_cfg_ready) model_limit = i_cfg_data;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_request(input t_kind kind, input logic [KEY_BITS-1:0] key,
                                 input logic [VALUE_BITS-1:0] value);
        t_request req;
        req.kind = kind;
        req.key = key;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // block until every request is in and every result is out
    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_s_axis_tvalid ||
               expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] lim);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random accesses, mostly over a key pool a little larger than the limit
    task automatic queue_random_phase(input logic [LIMIT_BITS-1:0] lim, input int count);
        int pool;
        int pick;
        logic [KEY_BITS-1:0] key_base;
        logic [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0] value;
        pool = (lim == 0) ? 2 : (lim > CAPACITY ? CAPACITY + 6 : lim + lim / 2 + 2);
        key_base = KEY_BITS'($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) key = key_base + KEY_BITS'($urandom_range(0, pool));
            else if (pick < 92) key = KEY_BITS'($urandom);
            else key = $urandom_range(0, 1) ? '1 : '0;
            pick = $urandom_range(0, 99);
            if (pick < 4) value = 32'h7fff_ffff;
            else if (pick < 8) value = 32'h8000_0000;
            else if (pick < 11) value = '1;
            else if (pick < 14) value = '0;
            else value = $urandom;
            queue_request($urandom_range(0, 1) ? KIND_PUT : KIND_GET, key, value);
        end
    endtask

    initial begin
        logic [LIMIT_BITS-1:0] limits[7];
        limits = '{5'd0, 5'd31, 5'd4, 5'd17, 5'd1, 5'd16, 5'd9};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty miss, key and value extremes, put hit, fill and evict
        tx_idle_pct = 28;
        rx_idle_pct = 78;
        queue_request(KIND_GET, 16'h0000, 32'hdead_beef);
        queue_request(KIND_PUT, 16'h0000, 32'h7fff_ffff);
        queue_request(KIND_PUT, 16'hffff, 32'h8000_0000);
        queue_request(KIND_GET, 16'hffff, 32'h0000_0000);
        queue_request(KIND_GET, 16'h0000, 32'hffff_ffff);
        queue_request(KIND_PUT, 16'h0000, 32'hffff_ffff);
        queue_request(KIND_GET, 16'h0000, 32'h0000_0000);
        for (int k = 1; k <= 14; k++)
            queue_request(KIND_PUT, KEY_BITS'(k), 32'h0101_0101 * k);
        queue_request(KIND_PUT, 16'h8000, 32'h5555_aaaa);
        queue_request(KIND_GET, 16'hffff, 32'h0000_0000);
        queue_request(KIND_GET, 16'h0001, 32'h0000_0000);

        // random phases over several limits, the first one below the occupancy
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            write_limit(limits[p]);
            if (p < 2) begin
                tx_idle_pct = 28;
                rx_idle_pct = 78;
            end else if (p < 4) begin
                tx_idle_pct = 78;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 4) stall_go = 1'b1;
            queue_random_phase(limits[p], PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        $display("%0d request beats, %0d results checked, %0d hits, %0d evictions",
                 beats_in, results_checked, hits_seen, evictions_seen);
        $display("limits 16 0 31 4 17 1 16 9, idle mixes and a %0d-cycle output stall",
                 STALL_CYCLES);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
